### design/tfb_pkg.sv
`timescale 1ns / 1ps

package tfb_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CFG_CTRL_FIRST = 8'd0;
  localparam logic [7:0] CFG_CTRL_SECOND = 8'd1;
  localparam logic [7:0] CFG_SRC_PORT = 8'd2;
  localparam logic [7:0] CFG_DST_PORT = 8'd3;

  localparam logic [7:0] RST_CTRL_FIRST = 8'h07;
  localparam logic [7:0] RST_CTRL_SECOND = 8'h0b;
  localparam logic [7:0] RST_SRC_PORT = 8'd21;
  localparam logic [7:0] RST_DST_PORT = 8'd21;

  localparam logic [2:0] HDR_CTRL_FIRST = 3'd0;
  localparam logic [2:0] HDR_CTRL_SECOND = 3'd1;
  localparam logic [2:0] HDR_SRC_PORT = 3'd2;
  localparam logic [2:0] HDR_DST_PORT = 3'd3;
  localparam logic [2:0] HDR_LENGTH = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] payload_count;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    in_word_t word;
    logic     first;
  } q_entry_t;

  typedef struct packed {
    logic [7:0] ctrl_first;
    logic [7:0] ctrl_second;
    logic [7:0] sport;
    logic [7:0] dst_port;
  } hdr_cfg_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     empty;
    logic     full;
    q_entry_t head;
  } q_status_t;

  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_DATA = 4'b0010,
    PH_SUMH = 4'b0100,
    PH_SUML = 4'b1000
  } phase_t;

endpackage

### design/tfb_front.sv
`timescale 1ns / 1ps

module tfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  tfb_pkg::in_word_t in_word,
  input  logic              q_full,
  output tfb_pkg::q_push_t  q_push,
  output tfb_pkg::hdr_cfg_t hdr_cfg
);

  tfb_pkg::hdr_cfg_t cfg_r, cfg_nxt;
  logic              in_pkt_r, in_pkt_nxt;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign hdr_cfg = cfg_r;

  // A word is the first of its packet when no packet is open on the input side.
  assign q_push.push = accept;
  assign q_push.entry.word = in_word;
  assign q_push.entry.first = !in_pkt_r;

  always_comb begin
    cfg_nxt = cfg_r;
    in_pkt_nxt = in_pkt_r;
    if (cfg_valid) begin
      case (cfg_index)
        tfb_pkg::CFG_CTRL_FIRST: cfg_nxt.ctrl_first = cfg_data;
        tfb_pkg::CFG_CTRL_SECOND: cfg_nxt.ctrl_second = cfg_data;
        tfb_pkg::CFG_SRC_PORT: cfg_nxt.sport = cfg_data;
        tfb_pkg::CFG_DST_PORT: cfg_nxt.dst_port = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
    if (accept) begin
      in_pkt_nxt = !in_word.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ctrl_first <= tfb_pkg::RST_CTRL_FIRST;
      cfg_r.ctrl_second <= tfb_pkg::RST_CTRL_SECOND;
      cfg_r.sport <= tfb_pkg::RST_SRC_PORT;
      cfg_r.dst_port <= tfb_pkg::RST_DST_PORT;
      in_pkt_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      in_pkt_r <= in_pkt_nxt;
    end
  end

endmodule

### design/tfb_queue.sv
`timescale 1ns / 1ps

module tfb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  tfb_pkg::q_push_t   q_push,
  input  logic               pop,
  output tfb_pkg::q_status_t q_status
);

  tfb_pkg::q_entry_t                  mem_r [tfb_pkg::QUEUE_DEPTH];
  logic [tfb_pkg::QUEUE_AW-1:0]       wptr_r, wptr_nxt;
  logic [tfb_pkg::QUEUE_AW-1:0]       rptr_r, rptr_nxt;
  logic [tfb_pkg::QUEUE_CW-1:0]       count_r, count_nxt;
  logic                               do_push, do_pop;

  assign q_status.empty = (count_r == '0);
  assign q_status.full = (count_r == tfb_pkg::QUEUE_CW'(tfb_pkg::QUEUE_DEPTH));
  assign q_status.head = mem_r[rptr_r];

  assign do_push = q_push.push && !q_status.full;
  assign do_pop = pop && !q_status.empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = rptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10: count_nxt = count_r + 1'b1;
      2'b01: count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      count_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### design/tfb_back.sv
`timescale 1ns / 1ps

module tfb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tfb_pkg::hdr_cfg_t  hdr_cfg,
  input  tfb_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tfb_pkg::out_word_t out_word
);

  tfb_pkg::phase_t    phase_r, phase_nxt;
  logic [2:0]         hdr_idx_r, hdr_idx_nxt;
  logic [15:0]        sum_r, sum_nxt;
  logic               odd_r, odd_nxt;
  logic               out_valid_r, out_valid_nxt;
  tfb_pkg::out_word_t out_word_r, out_word_nxt;
  tfb_pkg::q_entry_t  head;
  logic               emit;
  logic               take_data;
  logic               mix_en;
  logic [7:0]         mix_byte;
  logic [7:0]         hdr_byte;

  assign head = q_status.head;
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  assign emit = !q_status.empty && (!out_valid_r || out_ready);
  assign take_data = (phase_r == tfb_pkg::PH_DATA) ||
                     ((phase_r == tfb_pkg::PH_HEAD) && !head.first);

  always_comb begin
    case (hdr_idx_r)
      tfb_pkg::HDR_CTRL_FIRST: hdr_byte = hdr_cfg.ctrl_first;
      tfb_pkg::HDR_CTRL_SECOND: hdr_byte = hdr_cfg.ctrl_second;
      tfb_pkg::HDR_SRC_PORT: hdr_byte = hdr_cfg.sport;
      tfb_pkg::HDR_DST_PORT: hdr_byte = hdr_cfg.dst_port;
      default: hdr_byte = head.word.payload_count;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    sum_nxt = sum_r;
    odd_nxt = odd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt = out_word_r;
    pop = 1'b0;
    mix_en = 1'b0;
    mix_byte = head.word.payload_byte;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt.frame_end = 1'b0;
      if (take_data) begin
        mix_en = 1'b1;
        mix_byte = head.word.payload_byte;
        if (head.word.last_byte) begin
          phase_nxt = tfb_pkg::PH_SUMH;
        end else begin
          phase_nxt = tfb_pkg::PH_HEAD;
          pop = 1'b1;
        end
      end else begin
        case (phase_r)
          tfb_pkg::PH_HEAD: begin
            mix_en = 1'b1;
            mix_byte = hdr_byte;
            if (hdr_idx_r == tfb_pkg::HDR_LENGTH) begin
              phase_nxt = tfb_pkg::PH_DATA;
              hdr_idx_nxt = tfb_pkg::HDR_CTRL_FIRST;
            end else begin
              hdr_idx_nxt = hdr_idx_r + 3'd1;
            end
          end
          tfb_pkg::PH_SUMH: begin
            out_word_nxt.frame_byte = sum_r[15:8];
            phase_nxt = tfb_pkg::PH_SUML;
          end
          tfb_pkg::PH_SUML: begin
            out_word_nxt.frame_byte = sum_r[7:0];
            out_word_nxt.frame_end = 1'b1;
            phase_nxt = tfb_pkg::PH_HEAD;
            sum_nxt = '0;
            odd_nxt = 1'b0;
            pop = 1'b1;
          end
          default: begin
            phase_nxt = tfb_pkg::PH_HEAD;
            out_valid_nxt = out_valid_r && !out_ready;
          end
        endcase
      end
      if (mix_en) begin
        out_word_nxt.frame_byte = mix_byte;
        sum_nxt = sum_r ^ (odd_r ? {8'h00, mix_byte} : {mix_byte, 8'h00});
        odd_nxt = !odd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tfb_pkg::PH_HEAD;
      hdr_idx_r <= tfb_pkg::HDR_CTRL_FIRST;
      sum_r <= '0;
      odd_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      sum_r <= sum_nxt;
      odd_r <= odd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

endmodule

### design/transport_frame_builder_xor16_top.sv
`timescale 1ns / 1ps
// An accepted payload word is stored in the queue, and each frame byte is presented from an output register.
// A middle payload word yields one output byte, the first word of a packet six
// (five header bytes and the payload byte) and the last word three; the output sequencer
// drains one byte per cycle unless out_ready stalls it, while a four-word queue keeps the input
// side accepting until full. Reset is synchronous and active low; it empties the queue, closes any
// open packet and restores the header registers to their default values.

module transport_frame_builder_xor16_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  tfb_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output tfb_pkg::out_word_t out_word
);

  tfb_pkg::q_push_t   q_push;
  tfb_pkg::q_status_t q_status;
  tfb_pkg::hdr_cfg_t  hdr_cfg;
  logic               pop;

  tfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .q_full    (q_status.full),
    .q_push    (q_push),
    .hdr_cfg   (hdr_cfg)
  );

  tfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .pop      (pop),
    .q_status (q_status)
  );

  tfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hdr_cfg   (hdr_cfg),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

### design/tfb_checker.sv
`timescale 1ns / 1ps

module tfb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               in_valid,
  input logic               in_ready,
  input tfb_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_ready,
  input tfb_pkg::out_word_t out_word
);

  // A presented output word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind transport_frame_builder_xor16_top tfb_checker u_tfb_checker (.*);

### test/transport_frame_builder_xor16_top_tb.sv
`timescale 1ns / 1ps

module transport_frame_builder_xor16_top_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_SPACING = 250;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  tfb_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tfb_pkg::out_word_t out_word;

  transport_frame_builder_xor16_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word)
  );

  always #6 clk = ~clk;

  tfb_pkg::in_word_t payload_words[$];
  tfb_pkg::out_word_t frame_bytes_due[$];
  int error_count = 0;
  int items_taken = 0;

  tfb_pkg::hdr_cfg_t hdr_shadow;
  logic in_frame;
  logic [15:0] xor_sum;
  logic odd_pos;

  function automatic void push_frame_byte(input logic [7:0] b);
    tfb_pkg::out_word_t w;
    if (odd_pos) begin
      xor_sum[7:0] = xor_sum[7:0] ^ b;
    end else begin
      xor_sum[15:8] = xor_sum[15:8] ^ b;
    end
    odd_pos = ~odd_pos;
    w.frame_byte = b;
    w.frame_end = 1'b0;
    frame_bytes_due.push_back(w);
  endfunction

  function automatic void build_frame_bytes(input tfb_pkg::in_word_t iw);
    tfb_pkg::out_word_t w;
    if (!in_frame) begin
      xor_sum = '0;
      odd_pos = 1'b0;
      push_frame_byte(hdr_shadow.ctrl_first);
      push_frame_byte(hdr_shadow.ctrl_second);
      push_frame_byte(hdr_shadow.sport);
      push_frame_byte(hdr_shadow.dst_port);
      push_frame_byte(iw.payload_count);
      in_frame = 1'b1;
    end
    push_frame_byte(iw.payload_byte);
    if (iw.last_byte) begin
      w.frame_byte = xor_sum[15:8];
      w.frame_end = 1'b0;
      frame_bytes_due.push_back(w);
      w.frame_byte = xor_sum[7:0];
      w.frame_end = 1'b1;
      frame_bytes_due.push_back(w);
      in_frame = 1'b0;
      xor_sum = '0;
      odd_pos = 1'b0;
    end
  endfunction

  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        build_frame_bytes(in_word);
        items_taken <= items_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (payload_words.size() > 0) begin
          in_word <= payload_words.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int hold_left = 0;
  int hold_mark = 120;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (items_taken >= hold_mark) begin
      hold_left <= HOLD_CYCLES;
      hold_mark <= hold_mark + HOLD_SPACING;
    end
  end

  logic [1:0] rx_mode = 2'd0;
  int rx_left = 0;
  int rx_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left > 0) begin
        rx_left <= rx_left - 1;
      end else begin
        rx_mode <= 2'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 200);
      end
      rx_tick <= rx_tick + 1;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= 1'($urandom_range(0, 1));
          2'd2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ((rx_tick % 4) != 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    tfb_pkg::out_word_t due;
    if (rst_n && out_valid && out_ready) begin
      if (frame_bytes_due.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("unexpected frame word: byte %h end %b", out_word.frame_byte,
                   out_word.frame_end);
        end
        error_count <= error_count + 1;
      end else begin
        due = frame_bytes_due.pop_front();
        if (out_word.frame_byte !== due.frame_byte || out_word.frame_end !== due.frame_end)
        begin
          if (error_count < MAX_REPORTS) begin
            $display("frame word mismatch: byte exp %h got %h, end exp %b got %b",
                     due.frame_byte, out_word.frame_byte, due.frame_end, out_word.frame_end);
          end
          error_count <= error_count + 1;
        end
      end
    end
  end

  initial begin
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) begin
      @(posedge clk);
    end
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tfb_pkg::CFG_CTRL_FIRST: hdr_shadow.ctrl_first = val;
      tfb_pkg::CFG_CTRL_SECOND: hdr_shadow.ctrl_second = val;
      tfb_pkg::CFG_SRC_PORT: hdr_shadow.sport = val;
      tfb_pkg::CFG_DST_PORT: hdr_shadow.dst_port = val;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [7:0] val);
    write_reg(tfb_pkg::CFG_CTRL_FIRST, val);
    write_reg(tfb_pkg::CFG_CTRL_SECOND, val);
    write_reg(tfb_pkg::CFG_SRC_PORT, val);
    write_reg(tfb_pkg::CFG_DST_PORT, val);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (payload_words.size() != 0 || in_valid || frame_bytes_due.size() != 0);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic queue_word(input logic [7:0] b, input logic [7:0] cnt, input logic fin);
    tfb_pkg::in_word_t w;
    w.payload_byte = b;
    w.payload_count = cnt;
    w.last_byte = fin;
    payload_words.push_back(w);
  endtask

  task automatic queue_packet(input int len, input logic [7:0] cnt);
    for (int i = 0; i < len; i++) begin
      queue_word(8'($urandom_range(0, 255)), (i == 0) ? cnt : 8'($urandom_range(0, 255)),
                 i == len - 1);
    end
  endtask

  task automatic queue_random_phase(input int n_items);
    int queued;
    int len;
    int pick;
    logic [7:0] cnt;
    queued = 0;
    while (queued < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 8);
      end else if (pick < 96) begin
        len = $urandom_range(9, 30);
      end else begin
        len = $urandom_range(31, 90);
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        cnt = 8'(len);
      end else if (pick < 90) begin
        cnt = 8'($urandom_range(0, 255));
      end else if (pick < 95) begin
        cnt = 8'd0;
      end else begin
        cnt = 8'(len + 1);
      end
      queue_packet(len, cnt);
      queued += len;
    end
  endtask

  initial begin
    hdr_shadow.ctrl_first = tfb_pkg::RST_CTRL_FIRST;
    hdr_shadow.ctrl_second = tfb_pkg::RST_CTRL_SECOND;
    hdr_shadow.sport = tfb_pkg::RST_SRC_PORT;
    hdr_shadow.dst_port = tfb_pkg::RST_DST_PORT;
    in_frame = 1'b0;
    xor_sum = '0;
    odd_pos = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_word(8'h00, 8'd1, 1'b1);
    queue_word(8'hff, 8'hff, 1'b1);
    queue_word(8'h5a, 8'd0, 1'b0);
    queue_word(8'ha5, 8'hff, 1'b1);
    queue_word(8'h01, 8'd5, 1'b0);
    queue_word(8'h80, 8'h00, 1'b1);
    queue_word(8'haa, 8'd2, 1'b0);
    queue_word(8'h55, 8'd7, 1'b0);
    queue_word(8'hc3, 8'hff, 1'b0);
    queue_word(8'h3c, 8'h00, 1'b1);
    queue_packet(6, 8'd6);
    wait_drained();

    write_all_regs(8'h00);
    write_reg(8'(tfb_pkg::CFG_DST_PORT + 1), 8'hff);
    write_reg(8'hff, 8'h5a);
    queue_word(8'hff, 8'd1, 1'b1);
    queue_packet(3, 8'd3);
    queue_word(8'h12, 8'd4, 1'b0);
    wait_drained();

    // The open packet keeps the header it already sent; the new values apply
    // from the next packet on.
    write_all_regs(8'hff);
    queue_word(8'h34, 8'd0, 1'b1);
    queue_packet(2, 8'd2);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < 4; r++) begin
        if ($urandom_range(0, 9) < 7) begin
          case ($urandom_range(0, 3))
            0: write_reg(8'(r), 8'h00);
            1: write_reg(8'(r), 8'hff);
            default: write_reg(8'(r), 8'($urandom_range(0, 255)));
          endcase
        end
      end
      if ($urandom_range(0, 9) < 3) begin
        write_reg(8'($urandom_range(tfb_pkg::CFG_DST_PORT + 1, 255)),
                  8'($urandom_range(0, 255)));
      end
      queue_random_phase(60);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (frame_bytes_due.size() != 0) begin
      $display("%0d frame words never arrived", frame_bytes_due.size());
      error_count = error_count + 1;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
